// File: rtl/tadm_pkg.sv
// Shared widths, register codes and helpers for the arcade drive mixer.
`timescale 1ns / 1ps

package tadm_pkg;

    // Field widths
    localparam int CMD_W   = 16;           // throttle and turn, Q1.15
    localparam int GAIN_W  = 16;           // turn gains, Q4.12
    localparam int DRIVE_W = 16;           // motor drives, Q1.15

    // Internal widths
    localparam int SQ_W    = 2 * CMD_W - 1;        // magnitude of a squared command
    localparam int SHP_W   = CMD_W + 1;            // shaped command, -1.0 .. +1.0
    localparam int XY_W    = 2 * SHP_W - 2;        // x*y, |x*y| <= 2^30
    localparam int BX_W    = GAIN_W + SHP_W;       // b*x
    localparam int K_W     = GAIN_W + 2;           // 1.0 + a - b in Q.12
    localparam int BXY_W   = GAIN_W + XY_W;        // b*x*y
    localparam int KXY_W   = K_W + XY_W;           // k*x*y
    localparam int ACC_W   = 52;                   // Q.42 mix sums
    localparam int RND_SH  = 27;                   // Q.42 to Q.15
    localparam int BX_SH   = 15;                   // b*x in Q.27 to Q.42
    localparam int Q_W     = ACC_W - RND_SH;       // rounded sum before saturation

    // Constants
    localparam int SQ_HALF    = 1 << (CMD_W - 2);  // half an LSB after the square shift
    localparam int ROUND_HALF = 1 << (RND_SH - 1);
    localparam int Q12_ONE    = 4096;
    localparam int DRIVE_MAX  = 32767;
    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

    // APB side
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [0:0] {
        REG_FAST_GAIN = 1'b0,
        REG_SLOW_GAIN = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] fast;
        logic signed [GAIN_W-1:0] slow;
    } gain_t;

    // Round the squared magnitude to Q.15, restore the sign; pass through otherwise
    function automatic logic signed [SHP_W-1:0] shape_cmd(
        input logic signed [CMD_W-1:0] raw,
        input logic [SQ_W-1:0]          sq_mag,
        input logic                     sq
    );
        logic [SQ_W:0]           rnd;
        logic signed [SHP_W-1:0] mag;
        logic signed [SHP_W-1:0] res;
        rnd = {1'b0, sq_mag} + (SQ_W + 1)'(SQ_HALF);
        mag = $signed(rnd[SQ_W:CMD_W-1]);
        if (sq) begin
            res = raw[CMD_W-1] ? -mag : mag;
        end else begin
            res = SHP_W'(raw);
        end
        return res;
    endfunction

endpackage

// File: rtl/tadm_cfg.sv
// APB register file holding the fast and slow turn gains.
`timescale 1ns / 1ps

module tadm_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tadm_pkg::APB_AW-1:0]       paddr,
    input  logic [tadm_pkg::APB_DW-1:0]       pwdata,
    output logic [tadm_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    output tadm_pkg::gain_t                   gain
);

    tadm_pkg::reg_idx_t              idx;
    logic                            wr_en;
    logic signed [tadm_pkg::GAIN_W-1:0] fast_reg, fast_next;
    logic signed [tadm_pkg::GAIN_W-1:0] slow_reg, slow_next;

    assign pready = 1'b1;
    assign idx    = tadm_pkg::reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Decode the write
    always_comb begin
        fast_next = fast_reg;
        slow_next = slow_reg;
        if (wr_en) begin
            unique case (idx)
                tadm_pkg::REG_FAST_GAIN: fast_next = pwdata[tadm_pkg::GAIN_W-1:0];
                tadm_pkg::REG_SLOW_GAIN: slow_next = pwdata[tadm_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_reg <= tadm_pkg::GAIN_RESET;
            slow_reg <= tadm_pkg::GAIN_RESET;
        end else begin
            fast_reg <= fast_next;
            slow_reg <= slow_next;
        end
    end

    // Read back, sign-extended
    always_comb begin
        unique case (idx)
            tadm_pkg::REG_FAST_GAIN: prdata = tadm_pkg::APB_DW'(fast_reg);
            tadm_pkg::REG_SLOW_GAIN: prdata = tadm_pkg::APB_DW'(slow_reg);
            default:                 prdata = '0;
        endcase
    end

    assign gain.fast = fast_reg;
    assign gain.slow = slow_reg;

endmodule

// File: rtl/tadm_shape.sv
// Command shaping: square with sign kept, or pass through (two stages).
`timescale 1ns / 1ps

module tadm_shape (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tadm_pkg::CMD_W-1:0]    throttle,
    input  logic signed [tadm_pkg::CMD_W-1:0]    turn,
    input  logic                                 square_inputs,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tadm_pkg::SHP_W-1:0]    y,
    output logic signed [tadm_pkg::SHP_W-1:0]    x
);

    logic                                a_valid_reg;
    logic signed [tadm_pkg::CMD_W-1:0]   a_thr_reg, a_trn_reg;
    logic                                a_sq_reg;
    logic [tadm_pkg::SQ_W-1:0]           a_thr_sq_reg, a_trn_sq_reg;
    logic signed [2*tadm_pkg::CMD_W-1:0] thr_prod, trn_prod;

    logic                                b_valid_reg;
    logic signed [tadm_pkg::SHP_W-1:0]   b_y_reg, b_y_next;
    logic signed [tadm_pkg::SHP_W-1:0]   b_x_reg, b_x_next;

    logic en_a, en_b;

    // Advance a stage when it is empty or its successor moves
    assign en_b     = !b_valid_reg || out_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    // Stage A: square both commands
    assign thr_prod = throttle * throttle;
    assign trn_prod = turn * turn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en_a) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_thr_reg    <= throttle;
            a_trn_reg    <= turn;
            a_sq_reg     <= square_inputs;
            a_thr_sq_reg <= thr_prod[tadm_pkg::SQ_W-1:0];
            a_trn_sq_reg <= trn_prod[tadm_pkg::SQ_W-1:0];
        end
    end

    // Stage B: round, restore the sign or pass through
    assign b_y_next = tadm_pkg::shape_cmd(a_thr_reg, a_thr_sq_reg, a_sq_reg);
    assign b_x_next = tadm_pkg::shape_cmd(a_trn_reg, a_trn_sq_reg, a_sq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            b_y_reg <= b_y_next;
            b_x_reg <= b_x_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign y         = b_y_reg;
    assign x         = b_x_reg;

endmodule

// File: rtl/tadm_mix.sv
// Four-quadrant mix in Q.42: product stages and the quadrant sums.
`timescale 1ns / 1ps

module tadm_mix (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tadm_pkg::gain_t                      gain,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tadm_pkg::SHP_W-1:0]    y,
    input  logic signed [tadm_pkg::SHP_W-1:0]    x,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tadm_pkg::ACC_W-1:0]    left_acc,
    output logic signed [tadm_pkg::ACC_W-1:0]    right_acc
);

    // Stage C
    logic                                  c_valid_reg;
    logic signed [2*tadm_pkg::SHP_W-1:0]   xy_full;
    logic signed [tadm_pkg::XY_W-1:0]      c_xy_reg;
    logic signed [tadm_pkg::BX_W-1:0]      c_bx_reg, c_bx_next;
    logic signed [tadm_pkg::K_W-1:0]       c_k_reg, c_k_next;
    logic signed [tadm_pkg::SHP_W-1:0]     c_y_reg;
    logic                                  c_ypos_reg, c_xpos_reg;

    // Stage D
    logic                                  d_valid_reg;
    logic signed [tadm_pkg::BXY_W-1:0]     d_bxy_reg, d_bxy_next;
    logic signed [tadm_pkg::KXY_W-1:0]     d_kxy_reg, d_kxy_next;
    logic signed [tadm_pkg::BX_W-1:0]      d_bx_reg;
    logic signed [tadm_pkg::SHP_W-1:0]     d_y_reg;
    logic                                  d_ypos_reg, d_xpos_reg;

    // Stage E
    logic                                  e_valid_reg;
    logic signed [tadm_pkg::ACC_W-1:0]     e_l_reg, e_l_next;
    logic signed [tadm_pkg::ACC_W-1:0]     e_r_reg, e_r_next;
    logic signed [tadm_pkg::ACC_W-1:0]     y42, bx42, bxy42, kxy42;

    logic en_c, en_d, en_e;

    assign en_e     = !e_valid_reg || out_ready;
    assign en_d     = !d_valid_reg || en_e;
    assign en_c     = !c_valid_reg || en_d;
    assign in_ready = en_c;

    // Stage C: x*y, b*x and the blended gain k = 1 + a - b
    assign xy_full   = x * y;
    assign c_bx_next = gain.slow * x;
    assign c_k_next  = tadm_pkg::K_W'(tadm_pkg::Q12_ONE) + tadm_pkg::K_W'(gain.fast)
                       - tadm_pkg::K_W'(gain.slow);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en_c) begin
            c_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c) begin
            c_xy_reg   <= xy_full[tadm_pkg::XY_W-1:0];
            c_bx_reg   <= c_bx_next;
            c_k_reg    <= c_k_next;
            c_y_reg    <= y;
            c_ypos_reg <= (y > 0);
            c_xpos_reg <= (x > 0);
        end
    end

    // Stage D: b*x*y and k*x*y
    assign d_bxy_next = gain.slow * c_xy_reg;
    assign d_kxy_next = c_k_reg * c_xy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en_d) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            d_bxy_reg  <= d_bxy_next;
            d_kxy_reg  <= d_kxy_next;
            d_bx_reg   <= c_bx_reg;
            d_y_reg    <= c_y_reg;
            d_ypos_reg <= c_ypos_reg;
            d_xpos_reg <= c_xpos_reg;
        end
    end

    // Stage E: align every term to Q.42 and form the quadrant sums
    assign y42   = tadm_pkg::ACC_W'(d_y_reg) <<< tadm_pkg::RND_SH;
    assign bx42  = tadm_pkg::ACC_W'(d_bx_reg) <<< tadm_pkg::BX_SH;
    assign bxy42 = tadm_pkg::ACC_W'(d_bxy_reg);
    assign kxy42 = tadm_pkg::ACC_W'(d_kxy_reg);

    always_comb begin
        case ({d_ypos_reg, d_xpos_reg})
            2'b11: begin
                e_l_next = y42 - bxy42 + bx42;
                e_r_next = y42 - bx42 - kxy42;
            end
            2'b10: begin
                e_l_next = y42 + bx42 + kxy42;
                e_r_next = y42 + bxy42 - bx42;
            end
            2'b01: begin
                e_l_next = y42 + bx42 - kxy42;
                e_r_next = y42 - bxy42 - bx42;
            end
            default: begin
                e_l_next = y42 + bxy42 + bx42;
                e_r_next = y42 - bx42 + kxy42;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en_e) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_e) begin
            e_l_reg <= e_l_next;
            e_r_reg <= e_r_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign left_acc  = e_l_reg;
    assign right_acc = e_r_reg;

endmodule

// File: rtl/tadm_round.sv
// Output stage: round Q.42 sums to Q1.15 and saturate to +/-32767.
`timescale 1ns / 1ps

module tadm_round (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tadm_pkg::ACC_W-1:0]    left_acc,
    input  logic signed [tadm_pkg::ACC_W-1:0]    right_acc,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tadm_pkg::DRIVE_W-1:0]  left_drive,
    output logic signed [tadm_pkg::DRIVE_W-1:0]  right_drive
);

    logic                                  f_valid_reg;
    logic signed [tadm_pkg::DRIVE_W-1:0]   f_l_reg, f_l_next;
    logic signed [tadm_pkg::DRIVE_W-1:0]   f_r_reg, f_r_next;
    logic signed [tadm_pkg::ACC_W-1:0]     l_bias, r_bias;
    logic signed [tadm_pkg::Q_W-1:0]       l_q, r_q;
    logic signed [tadm_pkg::Q_W-1:0]       q_max, q_min;
    logic en_f;

    assign en_f     = !f_valid_reg || out_ready;
    assign in_ready = en_f;

    // Round half up: add half, floor by arithmetic shift
    assign l_bias = left_acc + tadm_pkg::ACC_W'(tadm_pkg::ROUND_HALF);
    assign r_bias = right_acc + tadm_pkg::ACC_W'(tadm_pkg::ROUND_HALF);
    assign l_q    = l_bias[tadm_pkg::ACC_W-1:tadm_pkg::RND_SH];
    assign r_q    = r_bias[tadm_pkg::ACC_W-1:tadm_pkg::RND_SH];
    assign q_max  = tadm_pkg::Q_W'(tadm_pkg::DRIVE_MAX);
    assign q_min  = -q_max;

    // Saturate to the symmetric drive range
    always_comb begin
        if (l_q > q_max) begin
            f_l_next = tadm_pkg::DRIVE_W'(tadm_pkg::DRIVE_MAX);
        end else if (l_q < q_min) begin
            f_l_next = -tadm_pkg::DRIVE_W'(tadm_pkg::DRIVE_MAX);
        end else begin
            f_l_next = l_q[tadm_pkg::DRIVE_W-1:0];
        end
        if (r_q > q_max) begin
            f_r_next = tadm_pkg::DRIVE_W'(tadm_pkg::DRIVE_MAX);
        end else if (r_q < q_min) begin
            f_r_next = -tadm_pkg::DRIVE_W'(tadm_pkg::DRIVE_MAX);
        end else begin
            f_r_next = r_q[tadm_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en_f) begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_f) begin
            f_l_reg <= f_l_next;
            f_r_reg <= f_r_next;
        end
    end

    assign out_valid   = f_valid_reg;
    assign left_drive  = f_l_reg;
    assign right_drive = f_r_reg;

endmodule

// File: rtl/tunable_arcade_drive_mixer_top.sv
// Top level of the tunable arcade drive mixer: stream ports, APB gains, pipeline.
`timescale 1ns / 1ps

// Arcade drive mixer: takes a throttle/turn pair in Q1.15 (optionally squared
// with sign kept) and returns left and right motor drives in Q1.15, saturated
// to +/-32767. The turn gain is blended between the fast and slow gains held
// at APB offsets 0x0 and 0x4 (signed Q4.12, reset 1.0). One transfer is taken
// every cycle unless m_tready back-pressure stalls the pipeline. There are six
// register stages: square, round and restore the sign, x*y and b*x, the two
// Q.42 products, the quadrant sums, and the round/saturate output register.
// Every stage holds its item under back-pressure, so a waiting result does not
// block new input until the pipeline is full.
module tunable_arcade_drive_mixer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [15:0] throttle, [31:16] turn
    input  logic                          s_tuser,   // [0] square_inputs
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [15:0] left_drive, [31:16] right_drive
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tadm_pkg::APB_AW-1:0]   paddr,
    input  logic [tadm_pkg::APB_DW-1:0]   pwdata,
    output logic [tadm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    tadm_pkg::gain_t                        gain;
    logic                                   shp_valid, shp_ready;
    logic signed [tadm_pkg::SHP_W-1:0]      shp_y, shp_x;
    logic                                   mix_valid, mix_ready;
    logic signed [tadm_pkg::ACC_W-1:0]      mix_l, mix_r;
    logic signed [tadm_pkg::DRIVE_W-1:0]    left_drive, right_drive;

    tadm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gain    (gain)
    );

    tadm_shape u_shape (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .throttle      (s_tdata[15:0]),
        .turn          (s_tdata[31:16]),
        .square_inputs (s_tuser),
        .out_valid     (shp_valid),
        .out_ready     (shp_ready),
        .y             (shp_y),
        .x             (shp_x)
    );

    tadm_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain      (gain),
        .in_valid  (shp_valid),
        .in_ready  (shp_ready),
        .y         (shp_y),
        .x         (shp_x),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .left_acc  (mix_l),
        .right_acc (mix_r)
    );

    tadm_round u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (mix_valid),
        .in_ready    (mix_ready),
        .left_acc    (mix_l),
        .right_acc   (mix_r),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .left_drive  (left_drive),
        .right_drive (right_drive)
    );

    assign m_tdata = {right_drive, left_drive};

    // Nothing leaves the pipeline in the cycle after reset
    a_no_out_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result transfer offered straight after reset");

    // An empty output register means every stage can advance
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    // Saturation keeps both drives off the most negative code
    a_drive_symmetric: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000))
        else $error("drive outside the symmetric range");

endmodule

// File: verif/tunable_arcade_drive_mixer_top_test.sv
// Self-checking testbench for the tunable arcade drive mixer top level.
`timescale 1ns / 1ps

module tunable_arcade_drive_mixer_top_test;
    import tadm_pkg::*;

    localparam int    RESET_CYCLES = 11;
    localparam int    CYCLE_LIMIT  = 200000;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    TAIL_CYCLES  = 20;
    localparam int    PHASE_COUNT  = 8;
    localparam int    PHASE_ITEMS  = 56;
    localparam longint ROUND_BIAS  = 64'sd1 <<< (RND_SH - 1);
    localparam longint CMD_ONE     = 64'sd32768;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] right;
        logic signed [DRIVE_W-1:0] left;
    } drive_pair_t;

    // Predicts the motor drives for each accepted command pair and checks results in order
    class drive_tracker;
        drive_pair_t              expected_drives[$];
        logic signed [GAIN_W-1:0] fast_gain;
        logic signed [GAIN_W-1:0] slow_gain;
        int                       mismatch_count;

        function new();
            fast_gain      = GAIN_RESET;
            slow_gain      = GAIN_RESET;
            mismatch_count = 0;
        endfunction

        function void set_gain(reg_idx_t idx, logic signed [GAIN_W-1:0] value);
            if (idx == REG_FAST_GAIN) begin
                fast_gain = value;
            end else begin
                slow_gain = value;
            end
        endfunction

        // Square with sign kept when asked, then clamp to plus or minus one
        function longint shape_command(logic signed [CMD_W-1:0] c, logic sq);
            longint v;
            longint m;
            v = c;
            if (sq) begin
                m = (v * v + 64'sd16384) >>> 15;
                v = (v >= 0) ? m : -m;
            end
            if (v > CMD_ONE) v = CMD_ONE;
            if (v < -CMD_ONE) v = -CMD_ONE;
            return v;
        endfunction

        // Round Q.42 half up to Q.15 and saturate
        function logic signed [DRIVE_W-1:0] round_drive(longint acc);
            longint q;
            q = (acc + ROUND_BIAS) >>> RND_SH;
            if (q > DRIVE_MAX) q = DRIVE_MAX;
            if (q < -DRIVE_MAX) q = -DRIVE_MAX;
            return q[DRIVE_W-1:0];
        endfunction

        function void note_command(logic signed [CMD_W-1:0] thr,
                                   logic signed [CMD_W-1:0] trn, logic sq);
            longint      y, x, b, k, y42, xy, bx, bxy, kxy, l, r;
            drive_pair_t d;
            y   = shape_command(thr, sq);
            x   = shape_command(trn, sq);
            b   = slow_gain;
            k   = Q12_ONE + longint'(fast_gain) - b;
            y42 = y <<< RND_SH;
            xy  = x * y;
            bx  = (b * x) <<< BX_SH;
            bxy = b * xy;
            kxy = k * xy;
            // Four-quadrant mix; zero falls on the not-positive side
            if (y > 0) begin
                if (x > 0) begin
                    l = y42 - (bxy - bx);
                    r = y42 - bx - kxy;
                end else begin
                    l = y42 + bx + kxy;
                    r = y42 + (bxy - bx);
                end
            end else begin
                if (x > 0) begin
                    l = y42 + bx - kxy;
                    r = y42 - (bxy + bx);
                end else begin
                    l = y42 + (bxy + bx);
                    r = y42 - bx + kxy;
                end
            end
            d.left  = round_drive(l);
            d.right = round_drive(r);
            expected_drives.push_back(d);
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_drives(logic [31:0] word);
            drive_pair_t got;
            drive_pair_t want;
            got = word;
            if (expected_drives.size() == 0) begin
                flag_mismatch($sformatf("result %h with no prediction pending", word));
            end else begin
                want = expected_drives.pop_front();
                if (got.left !== want.left)
                    flag_mismatch($sformatf("left_drive got %0d expected %0d",
                                            got.left, want.left));
                if (got.right !== want.right)
                    flag_mismatch($sformatf("right_drive got %0d expected %0d",
                                            got.right, want.right));
            end
        endtask
    endclass

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;   // [15:0] throttle, [31:16] turn
    logic              s_tuser  = 1'b0; // [0] square_inputs
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;         // [15:0] left_drive, [31:16] right_drive
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    drive_tracker tracker = new();
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    logic         hold_active    = 1'b0;
    int           cycle_count    = 0;
    event         hold_go;

    tunable_arcade_drive_mixer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Check each result transfer and drive the receiver's ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_drives(m_tdata);
        if (hold_active) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold the receiver off for a long stretch when asked
    initial begin
        forever begin
            @(hold_go);
            @(posedge aclk);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_active <= 1'b0;
        end
    end

    // Abort a run that stops making progress
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic write_gain(reg_idx_t idx, logic [GAIN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= APB_DW'($signed(value));
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_gain(idx, value);
    endtask

    task automatic send_command(logic [CMD_W-1:0] thr, logic [CMD_W-1:0] trn, logic sq);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {trn, thr};
        s_tuser  <= sq;
        do @(posedge aclk); while (!s_tready);
        tracker.note_command(thr, trn, sq);
    endtask

    task automatic drain_results();
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // Mostly full-range values, with extremes and near-zero values mixed in
    function automatic logic [CMD_W-1:0] pick_command();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            case ($urandom_range(4))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                3:       return 16'h0001;
                default: return 16'hFFFF;
            endcase
        end else if (sel < 30) begin
            return $urandom_range(1) ? -CMD_W'($urandom_range(511))
                                     : CMD_W'($urandom_range(511));
        end
        return CMD_W'($urandom());
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain(int phase, reg_idx_t idx);
        case (phase)
            0:       return 16'd4096;
            1:       return (idx == REG_FAST_GAIN) ? 16'h7FFF : 16'h8000;
            2:       return (idx == REG_FAST_GAIN) ? 16'h8000 : 16'h7FFF;
            3:       return 16'h0000;
            4:       return 16'h8000;
            5:       return 16'h7FFF;
            6:       return (idx == REG_FAST_GAIN) ? 16'd8192 : 16'd2048;
            default: return GAIN_W'($urandom());
        endcase
    endfunction

    task automatic run_directed();
        logic [CMD_W-1:0] thr_set [13];
        logic [CMD_W-1:0] trn_set [13];
        thr_set = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF,
                    16'h0000, 16'h8000, 16'h0001, 16'hFFFF, 16'h00B5, 16'h4000};
        trn_set = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000,
                    16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'hFF4B, 16'hC000};
        for (int i = 0; i < 13; i++) begin
            send_command(thr_set[i], trn_set[i], 1'b0);
            send_command(thr_set[i], trn_set[i], 1'b1);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes, zeros and the squared most negative command at reset gains
        run_directed();
        s_tvalid <= 1'b0;
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_gain(REG_FAST_GAIN, pick_gain(p, REG_FAST_GAIN));
            write_gain(REG_SLOW_GAIN, pick_gain(p, REG_SLOW_GAIN));
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            endcase
            // Back up the pipeline once while the sender keeps offering
            if (p == 4)
                -> hold_go;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_command(pick_command(), pick_command(), 1'($urandom_range(1)));
            s_tvalid <= 1'b0;
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.pending() != 0)
            tracker.flag_mismatch($sformatf("%0d predictions never matched by a result",
                                            tracker.pending()));
        if (tracker.mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
